/* rtl/core/utl1_pkg.sv */
// ----------------------------------------------------------------------------
// utl1_pkg
// Shared types and constants for the UTF-8 to Latin-1 decoder.
// ----------------------------------------------------------------------------
package utl1_pkg;

    localparam int SHOWN_WIDTH = 16;

    // Result error codes
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MISSING  = 3'd1,
        ERR_CONT     = 3'd2,
        ERR_OVERLONG = 3'd3,
        ERR_LEAD     = 3'd4
    } err_code_t;

    // Byte values and masks
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_NBSP    = 8'hA0;
    localparam logic [7:0] MASK_PAIR  = 8'hFE;
    localparam logic [7:0] LEAD_C2    = 8'hC2;
    localparam logic [7:0] LEAD_C0    = 8'hC0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] MASK_PAYL  = 8'h3F;
    localparam logic [7:0] MASK_L2    = 8'hE0;
    localparam logic [7:0] MASK_L3    = 8'hF0;
    localparam logic [7:0] MASK_L4    = 8'hF8;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_F0    = 8'hF0;

    // One input beat
    typedef struct packed {
        logic       last_in_string;
        logic [7:0] data_byte;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        err_code_t               error_code;
        logic [SHOWN_WIDTH-1:0]  replaced_count;
        logic                    string_done;
        logic                    char_valid;
        logic [7:0]              out_char;
    } result_t;

endpackage

/* rtl/core/utf8_to_latin1_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_latin1_decoder
// Stream decoder from UTF-8 bytes to ISO-8859-1 characters.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per beat (tlast marks the end of a string) and gives
// at most one Latin-1 result per byte: one byte is accepted every cycle while
// the result register is not stalled; each byte passes the input register,
// then the result register, which the single decode pass between them sets.
// Bytes that only start or continue a sequence give no result. Control and
// C1 characters and non-Latin-1 sequences come out as a counted space;
// encoding errors end the string with an error code and the rest of that
// string is dropped. Backpressure on m_tready reaches s_tready in the same
// cycle through the two pipeline registers.
module utf8_to_latin1_decoder
    import utl1_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_in_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_char, [23:8] replaced_count
    output logic [3:0]  m_tuser,   // [0] char_valid, [3:1] error_code
    output logic        m_tlast    // string_done
);

    in_beat_t s_beat;
    in_beat_t beat;
    logic     beat_valid;
    logic     out_ready;
    logic     step;
    logic     res_present;
    result_t  res;
    result_t  m_res;

    assign s_beat.data_byte      = s_tdata;
    assign s_beat.last_in_string = s_tlast;

    // Decode the held byte whenever the result register can take its result
    assign step = beat_valid && out_ready;

    utl1_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .take       (out_ready),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    utl1_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .beat        (beat),
        .res_present (res_present),
        .res         (res)
    );

    utl1_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (step),
        .res_present (res_present),
        .res         (res),
        .m_tready    (m_tready),
        .out_ready   (out_ready),
        .m_tvalid    (m_tvalid),
        .m_res       (m_res)
    );

    // Pack result beat
    assign m_tdata = {m_res.replaced_count, m_res.out_char};
    assign m_tuser = {m_res.error_code, m_res.char_valid};
    assign m_tlast = m_res.string_done;

endmodule

/* rtl/core/utl1_in_stage.sv */
// ----------------------------------------------------------------------------
// utl1_in_stage
// Input register: captures one byte beat and holds it until decoded.
// ----------------------------------------------------------------------------
module utl1_in_stage
    import utl1_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_beat_t s_beat,
    input  logic     take,
    output logic     beat_valid,
    output in_beat_t beat
);

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    // Accept a new beat whenever the held one is empty or being consumed
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on acceptance
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

/* rtl/core/utl1_decode.sv */
// ----------------------------------------------------------------------------
// utl1_decode
// Decoder state and single-pass byte decode, advanced once per consumed beat.
// ----------------------------------------------------------------------------
module utl1_decode
    import utl1_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  in_beat_t beat,
    output logic     res_present,
    output result_t  res
);

    typedef enum logic [1:0] {
        MODE_LEAD = 2'd0,
        MODE_PAIR = 2'd1,
        MODE_SKIP = 2'd2
    } mode_t;

    mode_t                  mode_reg,    mode_next;
    logic [1:0]             skip_reg,    skip_next;
    logic                   lhb_reg,     lhb_next;
    logic [COUNT_WIDTH-1:0] tally_reg,   tally_next;
    logic                   discard_reg, discard_next;

    logic [7:0]             b;
    logic                   last;
    logic                   is_cont;
    logic [7:0]             pair_char;
    logic [1:0]             skip_left;
    logic                   act_char;
    logic                   act_space;
    logic                   act_err;
    logic                   clear;
    err_code_t              err;
    logic [7:0]             ch;
    logic [COUNT_WIDTH-1:0] tally_bumped;
    logic [COUNT_WIDTH-1:0] tally_res;
    logic [SHOWN_WIDTH-1:0] shown;

    assign b         = beat.data_byte;
    assign last      = beat.last_in_string;
    assign is_cont   = (b & MASK_CONT) == CONT_TAG;
    assign pair_char = {1'b1, lhb_reg, b[5:0]};
    assign skip_left = (skip_reg == 2'd0) ? 2'd0 : skip_reg - 2'd1;

    // Saturating bump of the replacement tally
    assign tally_bumped = (tally_reg == {COUNT_WIDTH{1'b1}}) ? tally_reg
                                                             : tally_reg + 1'b1;

    // Classify the byte against the current mode
    always_comb begin
        act_char  = 1'b0;
        act_space = 1'b0;
        act_err   = 1'b0;
        err       = ERR_NONE;
        ch        = b;
        mode_next = mode_reg;
        skip_next = skip_reg;
        lhb_next  = lhb_reg;
        clear     = 1'b0;

        if (discard_reg) begin
            clear = last;
        end else begin
            unique case (mode_reg)
                MODE_PAIR: begin
                    if (!is_cont) begin
                        act_err = 1'b1;
                        err     = ERR_CONT;
                    end else if (pair_char < CH_NBSP) begin
                        act_space = 1'b1;
                    end else begin
                        act_char = 1'b1;
                        ch       = pair_char;
                    end
                end
                MODE_SKIP: begin
                    if (!is_cont) begin
                        act_err = 1'b1;
                        err     = ERR_CONT;
                    end else if (skip_left == 2'd0) begin
                        act_space = 1'b1;
                    end else if (last) begin
                        act_err = 1'b1;
                        err     = ERR_MISSING;
                    end else begin
                        skip_next = skip_left;
                    end
                end
                default: begin
                    if (!b[7]) begin
                        if (b < CH_SPACE || b == CH_DEL) begin
                            act_space = 1'b1;
                        end else begin
                            act_char = 1'b1;
                        end
                    end else if ((b & MASK_PAIR) == LEAD_C2) begin
                        if (last) begin
                            act_err = 1'b1;
                            err     = ERR_MISSING;
                        end else begin
                            lhb_next  = b[0];
                            mode_next = MODE_PAIR;
                        end
                    end else if ((b & MASK_PAIR) == LEAD_C0) begin
                        act_err = 1'b1;
                        err     = ERR_OVERLONG;
                    end else if ((b & MASK_L2) == LEAD_C0 ||
                                 (b & MASK_L3) == LEAD_E0 ||
                                 (b & MASK_L4) == LEAD_F0) begin
                        if (last) begin
                            act_err = 1'b1;
                            err     = ERR_MISSING;
                        end else begin
                            mode_next = MODE_SKIP;
                            if ((b & MASK_L2) == LEAD_C0) begin
                                skip_next = 2'd1;
                            end else if ((b & MASK_L3) == LEAD_E0) begin
                                skip_next = 2'd2;
                            end else begin
                                skip_next = 2'd3;
                            end
                        end
                    end else begin
                        act_err = 1'b1;
                        err     = ERR_LEAD;
                    end
                end
            endcase
        end

        // Return to lead-byte mode after a character
        if (act_char || act_space) begin
            mode_next = MODE_LEAD;
            skip_next = 2'd0;
            clear     = last;
        end
        if (act_err) begin
            clear = 1'b1;
        end

        // Tally and discard tracking
        tally_next   = act_space ? tally_bumped : tally_reg;
        discard_next = discard_reg;
        if (clear) begin
            mode_next    = MODE_LEAD;
            skip_next    = 2'd0;
            lhb_next     = 1'b0;
            tally_next   = '0;
            discard_next = 1'b0;
        end
        if (act_err) begin
            discard_next = !last;
        end
        if (act_space) begin
            ch = CH_SPACE;
        end else if (act_err) begin
            ch = 8'h00;
        end
    end

    assign tally_res = act_space ? tally_bumped : tally_reg;

    // Cap the reported tally at the result field width
    if (COUNT_WIDTH > SHOWN_WIDTH) begin : g_cap
        always_comb begin
            shown = (|tally_res[COUNT_WIDTH-1:SHOWN_WIDTH]) ? {SHOWN_WIDTH{1'b1}}
                                                            : tally_res[SHOWN_WIDTH-1:0];
        end
    end else begin : g_ext
        always_comb begin
            shown = SHOWN_WIDTH'(tally_res);
        end
    end

    // Assemble result beat
    always_comb begin
        res_present        = act_char || act_space || act_err;
        res.out_char       = ch;
        res.char_valid     = act_char || act_space;
        res.string_done    = act_err || last;
        res.replaced_count = shown;
        res.error_code     = err;
    end

    // Advance decoder state on each consumed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_LEAD;
            skip_reg    <= 2'd0;
            lhb_reg     <= 1'b0;
            tally_reg   <= '0;
            discard_reg <= 1'b0;
        end else if (step) begin
            mode_reg    <= mode_next;
            skip_reg    <= skip_next;
            lhb_reg     <= lhb_next;
            tally_reg   <= tally_next;
            discard_reg <= discard_next;
        end
    end

endmodule

/* rtl/core/utl1_out_stage.sv */
// ----------------------------------------------------------------------------
// utl1_out_stage
// Result register: holds one decoded beat until the downstream takes it.
// ----------------------------------------------------------------------------
module utl1_out_stage
    import utl1_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  logic    res_present,
    input  result_t res,
    input  logic    m_tready,
    output logic    out_ready,
    output logic    m_tvalid,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or when the held beat leaves this cycle
    assign out_ready  = !valid_reg || m_tready;
    assign valid_next = out_ready ? (load && res_present) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new result
    always_ff @(posedge aclk) begin
        if (out_ready && load && res_present) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

/* rtl/core/utl1_checker.sv */
// ----------------------------------------------------------------------------
// utl1_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module utl1_checker
    import utl1_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result changed while stalled");

    // Error results end the string and carry no character
    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:1] != ERR_NONE |->
        m_tlast && !m_tuser[0] && m_tdata[7:0] == 8'h00)
        else $error("error result malformed");

    // A character result carries no error
    a_char_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[3:1] == ERR_NONE)
        else $error("character with error code");

    // Error code within its defined range
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[3:1] == ERR_NONE || m_tuser[3:1] == ERR_MISSING ||
        m_tuser[3:1] == ERR_CONT || m_tuser[3:1] == ERR_OVERLONG ||
        m_tuser[3:1] == ERR_LEAD)
        else $error("undefined error code");

    // Reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind utf8_to_latin1_decoder utl1_checker u_chk (.*);

/* test/latin1_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latin1_result_checker
// Watches both streams of the UTF-8 to Latin-1 decoder, predicts the Latin-1
// result of every accepted byte and compares the result beats in order.
// ----------------------------------------------------------------------------
module latin1_result_checker
    import utl1_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_in_string
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] out_char, [23:8] replaced_count
    input  logic [3:0]  m_tuser,   // [0] char_valid, [3:1] error_code
    input  logic        m_tlast,   // string_done
    output int          mismatches,
    output int          pending
);

    typedef enum logic [1:0] {
        MODE_LEAD,
        MODE_PAIR,
        MODE_SKIP
    } dec_mode_t;

    localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = '1;

    // Decoder state as predicted
    dec_mode_t              mode;
    logic [1:0]             skip_left;
    logic                   pair_hi;
    logic [COUNT_WIDTH-1:0] tally;
    logic                   dropping;

    result_t expected_chars [$];
    result_t char_next;
    result_t oldest_char;
    bit      char_due;
    int      fail_total = 0;
    int      waiting_chars = 0;

    assign mismatches = fail_total;
    assign pending    = waiting_chars;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("checker: %s mismatch, got 0x%0h expected 0x%0h at %0t ns",
                 field, got, want, $realtime);
        fail_total++;
    endtask

    // Show the tally capped to the width of the result field
    function automatic logic [SHOWN_WIDTH-1:0] shown_tally();
        if (64'(tally) > 64'hFFFF) return '1;
        return SHOWN_WIDTH'(tally);
    endfunction

    task automatic clear_string();
        mode      = MODE_LEAD;
        skip_left = '0;
        pair_hi   = 1'b0;
        tally     = '0;
        dropping  = 1'b0;
    endtask

    task automatic give_result(input logic [7:0] ch, input logic valid,
                               input logic done, input err_code_t err);
        char_next.out_char       = ch;
        char_next.char_valid     = valid;
        char_next.string_done    = done;
        char_next.replaced_count = shown_tally();
        char_next.error_code     = err;
        char_due                 = 1'b1;
    endtask

    task automatic give_char(input logic [7:0] ch, input logic last);
        give_result(ch, 1'b1, last, ERR_NONE);
        mode      = MODE_LEAD;
        skip_left = '0;
        if (last) clear_string();
    endtask

    task automatic give_space(input logic last);
        if (tally != TALLY_MAX) tally = tally + 1'b1;
        give_char(CH_SPACE, last);
    endtask

    // Errors end the string; drop the rest unless this was its last byte
    task automatic give_error(input err_code_t err, input logic last);
        give_result(8'h00, 1'b0, 1'b1, err);
        clear_string();
        if (!last) dropping = 1'b1;
    endtask

    task automatic decode_utf8_byte(input logic [7:0] b, input logic last);
        logic [7:0] pair_char;
        char_due  = 1'b0;
        pair_char = {1'b1, pair_hi, b[5:0]};
        if (dropping) begin
            if (last) clear_string();
        end else if (mode == MODE_PAIR) begin
            if ((b & MASK_CONT) != CONT_TAG) give_error(ERR_CONT, last);
            else if (pair_char < CH_NBSP) give_space(last);
            else give_char(pair_char, last);
        end else if (mode == MODE_SKIP) begin
            if ((b & MASK_CONT) != CONT_TAG) begin
                give_error(ERR_CONT, last);
            end else begin
                if (skip_left != 2'd0) skip_left = skip_left - 2'd1;
                if (skip_left == 2'd0) give_space(last);
                else if (last) give_error(ERR_MISSING, last);
            end
        end else if (!b[7]) begin
            if (b < CH_SPACE || b == CH_DEL) give_space(last);
            else give_char(b, last);
        end else if ((b & MASK_PAIR) == LEAD_C2) begin
            if (last) begin
                give_error(ERR_MISSING, last);
            end else begin
                pair_hi = b[0];
                mode    = MODE_PAIR;
            end
        end else if ((b & MASK_PAIR) == LEAD_C0) begin
            give_error(ERR_OVERLONG, last);
        end else if ((b & MASK_L4) == MASK_L4 || (b & MASK_CONT) == CONT_TAG) begin
            give_error(ERR_LEAD, last);
        end else begin
            // Lead C4-F7: one space once all continuation bytes are in
            if ((b & MASK_L2) == LEAD_C0) skip_left = 2'd1;
            else if ((b & MASK_L3) == LEAD_E0) skip_left = 2'd2;
            else skip_left = 2'd3;
            if (last) give_error(ERR_MISSING, last);
            else mode = MODE_SKIP;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_string();
            expected_chars.delete();
        end else begin
            // Predict on each accepted input beat
            if (s_tvalid && s_tready) begin
                decode_utf8_byte(s_tdata, s_tlast);
                if (char_due) expected_chars.push_back(char_next);
            end
            // Compare each result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected result beat", 32'(m_tdata), 32'd0);
                end else begin
                    oldest_char = expected_chars.pop_front();
                    if (m_tdata[7:0] != oldest_char.out_char)
                        report_mismatch("out_char", 32'(m_tdata[7:0]),
                                        32'(oldest_char.out_char));
                    if (m_tuser[0] != oldest_char.char_valid)
                        report_mismatch("char_valid", 32'(m_tuser[0]),
                                        32'(oldest_char.char_valid));
                    if (m_tlast != oldest_char.string_done)
                        report_mismatch("string_done", 32'(m_tlast),
                                        32'(oldest_char.string_done));
                    if (m_tdata[23:8] != oldest_char.replaced_count)
                        report_mismatch("replaced_count", 32'(m_tdata[23:8]),
                                        32'(oldest_char.replaced_count));
                    if (m_tuser[3:1] != oldest_char.error_code)
                        report_mismatch("error_code", 32'(m_tuser[3:1]),
                                        32'(oldest_char.error_code));
                end
            end
        end
        waiting_chars = expected_chars.size();
    end

endmodule

/* test/tb_utf8_to_latin1_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_latin1_decoder
// Drives UTF-8 strings into the decoder: a directed set of characters and
// encoding errors, one long string of control characters, then random
// strings under several idle and backpressure patterns, with one long
// receiver hold-off. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_utf8_to_latin1_decoder
    import utl1_pkg::*;
();

    localparam int COUNT_WIDTH    = 16;
    localparam int BYTES_PER_MIX  = 230;
    localparam int LONG_BYTES     = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 20;

    typedef enum logic [3:0] {
        PH_RESET,
        PH_DIRECTED,
        PH_LONG,
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE,
        PH_HOLD,
        PH_DRAIN
    } phase_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int     mismatches;
    int     pending;
    phase_t phase          = PH_RESET;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    logic   hold_off       = 1'b0;
    logic [7:0] utf8_text [$];

    // Directed strings, bit 8 marks the last byte of a string
    logic [8:0] directed_beats [0:25] = '{
        9'h041, 9'h000, 9'h01F, 9'h07F, 9'h0C2, 9'h080, 9'h0C3, 9'h0BF,
        9'h0C2, 9'h0A0, 9'h17E,
        9'h0D0, 9'h0B0, 9'h0E2, 9'h082, 9'h1AC,
        9'h1C3,
        9'h0C3, 9'h041, 9'h17A,
        9'h0C0, 9'h1FF,
        9'h1FF,
        9'h180,
        9'h0F0, 9'h19F
    };

    utf8_to_latin1_decoder #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    latin1_result_checker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result stream at random, or hold it off entirely
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold off the receiver long enough for the decoder to back up
    initial begin : long_holdoff
        wait (phase == PH_HOLD);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin : run_limit
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Offer one byte and return at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic int conts_after(input logic [7:0] lead);
        if (lead < 8'hE0) return 1;
        if (lead < 8'hF0) return 2;
        return 3;
    endfunction

    // Append one character, mostly well formed, sometimes noise or broken
    task automatic append_char();
        int         pick;
        int         n_cont;
        int         n_keep;
        logic [7:0] lead;
        logic [7:0] stray;
        pick = $urandom_range(99);
        if (pick < 25) begin
            utf8_text.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 35) begin
            utf8_text.push_back($urandom_range(1) ? CH_DEL : 8'($urandom_range(8'h1F)));
        end else if (pick < 80) begin
            if (pick < 55) lead = {7'b1100001, 1'($urandom)};
            else if (pick < 65) lead = 8'($urandom_range(8'hC4, 8'hDF));
            else if (pick < 73) lead = 8'($urandom_range(8'hE0, 8'hEF));
            else lead = 8'($urandom_range(8'hF0, 8'hF7));
            utf8_text.push_back(lead);
            repeat (conts_after(lead)) utf8_text.push_back(cont_byte());
        end else if (pick < 88) begin
            utf8_text.push_back(8'($urandom));
        end else begin
            case ($urandom_range(3))
                0: utf8_text.push_back({7'b1100000, 1'($urandom)});
                1: utf8_text.push_back($urandom_range(1) ?
                                       8'($urandom_range(8'h80, 8'hBF)) :
                                       8'($urandom_range(8'hF8, 8'hFF)));
                default: begin
                    // Cut a sequence short, sometimes with a stray byte after
                    lead   = 8'($urandom_range(8'hC2, 8'hF7));
                    n_cont = conts_after(lead);
                    n_keep = $urandom_range(n_cont - 1);
                    utf8_text.push_back(lead);
                    repeat (n_keep) utf8_text.push_back(cont_byte());
                    if ($urandom_range(1)) begin
                        stray = 8'($urandom);
                        if (stray[7:6] == 2'b10) stray[6] = 1'b1;
                        utf8_text.push_back(stray);
                    end
                end
            endcase
        end
    endtask

    // Send random strings under one idle and stall pattern
    task automatic run_mix(input phase_t ph, input int idle, input int stall);
        int sent;
        phase          = ph;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        sent           = 0;
        while (sent < BYTES_PER_MIX) begin
            utf8_text.delete();
            repeat ($urandom_range(1, 10)) append_char();
            foreach (utf8_text[i]) send_byte(utf8_text[i], i == utf8_text.size() - 1);
            sent += utf8_text.size();
        end
    endtask

    initial begin : stimulus
        int waited;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        phase = PH_DIRECTED;
        foreach (directed_beats[i]) send_byte(directed_beats[i][7:0], directed_beats[i][8]);

        // One long string of control characters to run the count up
        phase = PH_LONG;
        repeat (LONG_BYTES) send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b1);

        run_mix(PH_FREE, 0, 0);
        run_mix(PH_SEND_IDLE, 72, 0);
        run_mix(PH_RECV_STALL, 0, 72);
        run_mix(PH_BOTH_IDLE, 8, 8);
        run_mix(PH_HOLD, 0, 0);

        // Drain the results still in flight
        phase          = PH_DRAIN;
        recv_stall_pct = 0;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
